@@ design/gbrw_pkg.sv @@
// ----------------------------------------------------------------------------
// gbrw_pkg
// shared types and constants of the grid block range walker
// ----------------------------------------------------------------------------
package gbrw_pkg;

  // grid limits
  localparam int MAX_GRID = 256;
  localparam int MAX_SPAN = 8;
  localparam int GRID_W   = 9;                      // holds 1..MAX_GRID
  localparam int CELL_W   = 8;                      // holds 0..MAX_GRID-1
  localparam int CNT_W    = $clog2(MAX_SPAN + 1);   // holds 1..MAX_SPAN

  // coordinate arithmetic
  localparam int COORD_W = 32;                      // Q16.16 operands
  localparam int DIFF_W  = COORD_W + 1;             // coordinate minus origin
  localparam int PROD_W  = 2 * COORD_W;             // Q32.32 product
  localparam int BLK_W   = COORD_W + 1;             // signed block number

  // image counts: kept a little wider than the port so that the walk of at
  // most MAX_SPAN blocks past a saturated start still saturates on output
  localparam int OUT_W   = 16;
  localparam int IMG_W   = OUT_W + 2;
  localparam int IMG_LIM = (1 << (OUT_W - 1)) - 1 + 2 * MAX_SPAN;
  localparam logic signed [IMG_W-1:0] IMG_MAX = IMG_W'(IMG_LIM);
  localparam logic signed [IMG_W-1:0] IMG_MIN = IMG_W'(-IMG_LIM - 1);

  // floor divider
  localparam int DIV_BITS  = 4;                     // quotient bits per cycle
  localparam int DIV_W     = ((BLK_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
  localparam int DIV_STEPS = DIV_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // descriptor queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_BLOCK_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_BLOCK_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_X      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_Y      = 3'd7;

  // live configuration, block counts already folded into 1..MAX_GRID
  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0]        inv_x;
    logic [COORD_W-1:0]        inv_y;
    logic [GRID_W-1:0]         n_x;
    logic [GRID_W-1:0]         n_y;
    logic                      wrap_x;
    logic                      wrap_y;
  } cfg_t;

  // one rectangle, ready to walk
  typedef struct packed {
    logic [CELL_W-1:0]       cell_x;
    logic signed [IMG_W-1:0] img_x;
    logic [CNT_W-1:0]        cnt_x;
    logic [CELL_W-1:0]       cell_y;
    logic signed [IMG_W-1:0] img_y;
    logic [CNT_W-1:0]        cnt_y;
    logic                    clip;
  } desc_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIFF,
    F_MUL,
    F_FLOOR,
    F_CLAMP,
    F_START,
    F_DIV,
    F_PUSH
  } front_state_t;

endpackage

@@ design/gbrw_div.sv @@
// ----------------------------------------------------------------------------
// gbrw_div
// iterative floor division of a signed block number by the block count
// ----------------------------------------------------------------------------
module gbrw_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [gbrw_pkg::BLK_W-1:0]   k,
  input  logic [gbrw_pkg::GRID_W-1:0]         n,
  output logic                                done,
  output logic [gbrw_pkg::CELL_W-1:0]         cell_idx,
  output logic signed [gbrw_pkg::IMG_W-1:0]   image
);

  logic                              busy;
  logic [gbrw_pkg::STEP_W-1:0]       step;
  logic                              neg;
  logic [gbrw_pkg::DIV_W-1:0]        dvd;
  logic [gbrw_pkg::DIV_W-1:0]        quo;
  logic [gbrw_pkg::GRID_W-1:0]       rem;

  logic signed [gbrw_pkg::DIV_W-1:0] k_ext;
  logic [gbrw_pkg::DIV_W-1:0]        k_mag;
  logic [gbrw_pkg::DIV_W-1:0]        dvd_next;
  logic [gbrw_pkg::DIV_W-1:0]        quo_next;
  logic [gbrw_pkg::GRID_W-1:0]       rem_next;
  logic [gbrw_pkg::GRID_W:0]         trial;
  logic                              fix;
  logic [gbrw_pkg::DIV_W:0]          quo_mag;

  assign k_ext = gbrw_pkg::DIV_W'(k);
  assign k_mag = k[gbrw_pkg::BLK_W-1] ? gbrw_pkg::DIV_W'(-k_ext) : gbrw_pkg::DIV_W'(k_ext);

  // restoring division, a few quotient bits per cycle
  always_comb begin
    rem_next = rem;
    dvd_next = dvd;
    quo_next = quo;
    trial    = '0;
    for (int i = 0; i < gbrw_pkg::DIV_BITS; i++) begin
      trial    = {rem_next, dvd_next[gbrw_pkg::DIV_W-1]};
      dvd_next = {dvd_next[gbrw_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, n}) begin
        rem_next = gbrw_pkg::GRID_W'(trial - {1'b0, n});
        quo_next = {quo_next[gbrw_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_next = gbrw_pkg::GRID_W'(trial);
        quo_next = {quo_next[gbrw_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && (step == gbrw_pkg::STEP_W'(gbrw_pkg::DIV_STEPS - 1))) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step <= '0;
      neg  <= k[gbrw_pkg::BLK_W-1];
      dvd  <= k_mag;
      quo  <= '0;
      rem  <= '0;
    end else if (busy) begin
      step <= step + gbrw_pkg::STEP_W'(1);
      dvd  <= dvd_next;
      quo  <= quo_next;
      rem  <= rem_next;
    end
  end

  // floor correction for negative numbers, then clamp of the image count
  assign fix      = neg && (rem != '0);
  assign quo_mag  = {1'b0, quo} + (gbrw_pkg::DIV_W + 1)'(fix);
  assign cell_idx = fix ? gbrw_pkg::CELL_W'(n - rem) : gbrw_pkg::CELL_W'(rem);

  always_comb begin
    if (!neg) begin
      if (quo_mag > (gbrw_pkg::DIV_W + 1)'(gbrw_pkg::IMG_LIM)) begin
        image = gbrw_pkg::IMG_MAX;
      end else begin
        image = gbrw_pkg::IMG_W'(quo_mag);
      end
    end else begin
      if (quo_mag > (gbrw_pkg::DIV_W + 1)'(gbrw_pkg::IMG_LIM + 1)) begin
        image = gbrw_pkg::IMG_MIN;
      end else begin
        image = gbrw_pkg::IMG_W'(-quo_mag);
      end
    end
  end

endmodule

@@ design/gbrw_front.sv @@
// ----------------------------------------------------------------------------
// gbrw_front
// accepts a rectangle, finds the block range per axis and its first cell
// ----------------------------------------------------------------------------
module gbrw_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  gbrw_pkg::cfg_t                       cfg,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [gbrw_pkg::COORD_W-1:0]  rect_xmin,
  input  logic signed [gbrw_pkg::COORD_W-1:0]  rect_xmax,
  input  logic signed [gbrw_pkg::COORD_W-1:0]  rect_ymin,
  input  logic signed [gbrw_pkg::COORD_W-1:0]  rect_ymax,
  output logic                                 push,
  output gbrw_pkg::desc_t                      desc,
  input  logic                                 full
);

  typedef struct packed {
    logic signed [gbrw_pkg::BLK_W-1:0] lo;
    logic [gbrw_pkg::CNT_W-1:0]        cnt;
    logic                              clip;
  } axis_t;

  // clamp on a closed axis, order fix, span cut
  function automatic axis_t clamp_axis(
    input logic signed [gbrw_pkg::BLK_W-1:0] lo_in,
    input logic signed [gbrw_pkg::BLK_W-1:0] hi_in,
    input logic [gbrw_pkg::GRID_W-1:0]       n,
    input logic                              wrap
  );
    logic signed [gbrw_pkg::BLK_W-1:0] lo;
    logic signed [gbrw_pkg::BLK_W-1:0] hi;
    logic signed [gbrw_pkg::BLK_W-1:0] nb;
    logic signed [gbrw_pkg::BLK_W:0]   span;
    axis_t                             a;
    lo = lo_in;
    hi = hi_in;
    nb = $signed({{(gbrw_pkg::BLK_W - gbrw_pkg::GRID_W){1'b0}}, n});
    if (!wrap) begin
      if (lo < 0) begin
        lo = '0;
        if (hi < 0) begin
          hi = '0;
        end
      end
      if (hi >= nb) begin
        hi = gbrw_pkg::BLK_W'(nb - 1);
        if (lo >= nb) begin
          lo = gbrw_pkg::BLK_W'(nb - 1);
        end
      end
    end
    if (hi < lo) begin
      hi = lo;
    end
    span = (gbrw_pkg::BLK_W + 1)'(hi) - (gbrw_pkg::BLK_W + 1)'(lo);
    a.lo = lo;
    if (span >= gbrw_pkg::MAX_SPAN) begin
      a.cnt  = gbrw_pkg::CNT_W'(gbrw_pkg::MAX_SPAN);
      a.clip = 1'b1;
    end else begin
      a.cnt  = gbrw_pkg::CNT_W'(span + 1);
      a.clip = 1'b0;
    end
    return a;
  endfunction

  gbrw_pkg::front_state_t state, state_next;

  // coordinate order: x min, x max, y min, y max
  logic signed [gbrw_pkg::COORD_W-1:0] rect [4];
  logic                                neg [4];
  logic [gbrw_pkg::COORD_W-1:0]        mag [4];
  logic [gbrw_pkg::PROD_W-1:0]         prod [4];
  logic signed [gbrw_pkg::BLK_W-1:0]   fl [4];
  axis_t                               ax, ay;

  logic signed [gbrw_pkg::DIFF_W-1:0]  diff [4];
  logic [gbrw_pkg::COORD_W-1:0]        mag_next [4];
  logic [gbrw_pkg::PROD_W-1:0]         prod_next [4];
  logic [gbrw_pkg::BLK_W-1:0]          ceil_mag [4];
  logic signed [gbrw_pkg::BLK_W-1:0]   fl_next [4];

  logic                                accept;
  logic                                div_start;
  logic                                done_x, done_y;
  logic [gbrw_pkg::CELL_W-1:0]         cell_x, cell_y;
  logic signed [gbrw_pkg::IMG_W-1:0]   img_x, img_y;

  assign accept = in_valid && !in_stall;

  // coordinate minus origin, then magnitude and sign
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      diff[i] = gbrw_pkg::DIFF_W'(rect[i])
              - gbrw_pkg::DIFF_W'((i < 2) ? $signed(cfg.origin_x) : $signed(cfg.origin_y));
      mag_next[i] = diff[i][gbrw_pkg::DIFF_W-1] ? gbrw_pkg::COORD_W'(-diff[i])
                                                : gbrw_pkg::COORD_W'(diff[i]);
    end
  end

  // Q16.16 magnitude times Q16.16 reciprocal
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_next[i] = gbrw_pkg::PROD_W'(mag[i])
                   * gbrw_pkg::PROD_W'((i < 2) ? cfg.inv_x : cfg.inv_y);
    end
  end

  // floor of the product: a negative value with a fraction rounds away
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ceil_mag[i] = {1'b0, prod[i][gbrw_pkg::PROD_W-1:gbrw_pkg::COORD_W]}
                  + gbrw_pkg::BLK_W'(neg[i] && (prod[i][gbrw_pkg::COORD_W-1:0] != '0));
      fl_next[i] = neg[i] ? $signed(gbrw_pkg::BLK_W'(-ceil_mag[i])) : $signed(ceil_mag[i]);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      gbrw_pkg::F_IDLE: begin
        if (accept) begin
          rect[0] <= rect_xmin;
          rect[1] <= rect_xmax;
          rect[2] <= rect_ymin;
          rect[3] <= rect_ymax;
        end
      end
      gbrw_pkg::F_DIFF: begin
        for (int i = 0; i < 4; i++) begin
          neg[i] <= diff[i][gbrw_pkg::DIFF_W-1];
          mag[i] <= mag_next[i];
        end
      end
      gbrw_pkg::F_MUL: begin
        for (int i = 0; i < 4; i++) begin
          prod[i] <= prod_next[i];
        end
      end
      gbrw_pkg::F_FLOOR: begin
        for (int i = 0; i < 4; i++) begin
          fl[i] <= fl_next[i];
        end
      end
      gbrw_pkg::F_CLAMP: begin
        ax <= clamp_axis(fl[0], fl[1], cfg.n_x, cfg.wrap_x);
        ay <= clamp_axis(fl[2], fl[3], cfg.n_y, cfg.wrap_y);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbrw_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      gbrw_pkg::F_IDLE:  if (accept) state_next = gbrw_pkg::F_DIFF;
      gbrw_pkg::F_DIFF:  state_next = gbrw_pkg::F_MUL;
      gbrw_pkg::F_MUL:   state_next = gbrw_pkg::F_FLOOR;
      gbrw_pkg::F_FLOOR: state_next = gbrw_pkg::F_CLAMP;
      gbrw_pkg::F_CLAMP: state_next = gbrw_pkg::F_START;
      gbrw_pkg::F_START: state_next = gbrw_pkg::F_DIV;
      gbrw_pkg::F_DIV:   if (done_x && done_y) state_next = gbrw_pkg::F_PUSH;
      gbrw_pkg::F_PUSH:  if (!full) state_next = gbrw_pkg::F_IDLE;
      default:           state_next = gbrw_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != gbrw_pkg::F_IDLE);
    div_start = (state == gbrw_pkg::F_START);
    push      = (state == gbrw_pkg::F_PUSH) && !full;
  end

  gbrw_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .k        (ax.lo),
    .n        (cfg.n_x),
    .done     (done_x),
    .cell_idx (cell_x),
    .image    (img_x)
  );

  gbrw_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .k        (ay.lo),
    .n        (cfg.n_y),
    .done     (done_y),
    .cell_idx (cell_y),
    .image    (img_y)
  );

  always_comb begin
    desc.cell_x = cell_x;
    desc.img_x  = img_x;
    desc.cnt_x  = ax.cnt;
    desc.cell_y = cell_y;
    desc.img_y  = img_y;
    desc.cnt_y  = ay.cnt;
    desc.clip   = ax.clip || ay.clip;
  end

endmodule

@@ design/gbrw_queue.sv @@
// ----------------------------------------------------------------------------
// gbrw_queue
// short descriptor queue between the front and the back
// ----------------------------------------------------------------------------
module gbrw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gbrw_pkg::desc_t din,
  output logic            full,
  input  logic            pop,
  output gbrw_pkg::desc_t dout,
  output logic            empty
);

  gbrw_pkg::desc_t              entry [gbrw_pkg::QDEPTH];
  logic [gbrw_pkg::QPTR_W-1:0]  wr_ptr;
  logic [gbrw_pkg::QPTR_W-1:0]  rd_ptr;
  logic [gbrw_pkg::QCNT_W-1:0]  count;

  assign full  = (count == gbrw_pkg::QCNT_W'(gbrw_pkg::QDEPTH));
  assign empty = (count == '0);
  assign dout  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + gbrw_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + gbrw_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + gbrw_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - gbrw_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= din;
    end
  end

endmodule

@@ design/gbrw_back.sv @@
// ----------------------------------------------------------------------------
// gbrw_back
// walks the blocks of one rectangle, one output beat per cycle while out_stall is low
// ----------------------------------------------------------------------------
module gbrw_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [gbrw_pkg::GRID_W-1:0]         n_x,
  input  logic [gbrw_pkg::GRID_W-1:0]         n_y,
  input  gbrw_pkg::desc_t                     desc,
  input  logic                                empty,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gbrw_pkg::OUT_W-1:0]          block_index,
  output logic signed [gbrw_pkg::OUT_W-1:0]   image_x,
  output logic signed [gbrw_pkg::OUT_W-1:0]   image_y,
  output logic                                last_block,
  output logic                                span_clipped
);

  localparam int OUT_MAX = (1 << (gbrw_pkg::OUT_W - 1)) - 1;

  function automatic logic signed [gbrw_pkg::OUT_W-1:0] sat_image(
    input logic signed [gbrw_pkg::IMG_W-1:0] v
  );
    logic signed [gbrw_pkg::OUT_W-1:0] r;
    if (v > $signed(gbrw_pkg::IMG_W'(OUT_MAX))) begin
      r = gbrw_pkg::OUT_W'(OUT_MAX);
    end else if (v < $signed(gbrw_pkg::IMG_W'(-OUT_MAX - 1))) begin
      r = gbrw_pkg::OUT_W'(-OUT_MAX - 1);
    end else begin
      r = gbrw_pkg::OUT_W'(v);
    end
    return r;
  endfunction

  logic                                active;
  logic [gbrw_pkg::CNT_W-1:0]          col, row;
  logic [gbrw_pkg::CNT_W-1:0]          cnt_x, cnt_y;
  logic [gbrw_pkg::CELL_W-1:0]         start_cell_x, cell_x, cell_y;
  logic signed [gbrw_pkg::IMG_W-1:0]   start_img_x, img_x, img_y;
  logic                                clip;

  logic                                load;
  logic                                emit;
  logic                                row_end;
  logic                                at_last;
  logic                                x_wrap, y_wrap;
  logic [gbrw_pkg::GRID_W+gbrw_pkg::CELL_W-1:0] row_base;
  logic [gbrw_pkg::OUT_W-1:0]          index_next;

  always_comb begin
    load    = !out_valid || !out_stall;
    emit    = active && load;
    row_end = (col == cnt_x - gbrw_pkg::CNT_W'(1));
    at_last = row_end && (row == cnt_y - gbrw_pkg::CNT_W'(1));
    pop     = !empty && (!active || (emit && at_last));
    x_wrap  = ({1'b0, cell_x} == gbrw_pkg::GRID_W'(n_x - gbrw_pkg::GRID_W'(1)));
    y_wrap  = ({1'b0, cell_y} == gbrw_pkg::GRID_W'(n_y - gbrw_pkg::GRID_W'(1)));
    row_base   = n_x * cell_y;
    index_next = gbrw_pkg::OUT_W'(row_base) + gbrw_pkg::OUT_W'(cell_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= emit;
      end
      if (pop) begin
        active <= 1'b1;
      end else if (emit && at_last) begin
        active <= 1'b0;
      end
    end
  end

  // walk position: columns inner, rows outer, cells wrap at the block count
  always_ff @(posedge clk) begin
    if (pop) begin
      col          <= '0;
      row          <= '0;
      cnt_x        <= desc.cnt_x;
      cnt_y        <= desc.cnt_y;
      start_cell_x <= desc.cell_x;
      start_img_x  <= desc.img_x;
      cell_x       <= desc.cell_x;
      img_x        <= desc.img_x;
      cell_y       <= desc.cell_y;
      img_y        <= desc.img_y;
      clip         <= desc.clip;
    end else if (emit && !at_last) begin
      if (row_end) begin
        col    <= '0;
        row    <= row + gbrw_pkg::CNT_W'(1);
        cell_x <= start_cell_x;
        img_x  <= start_img_x;
        if (y_wrap) begin
          cell_y <= '0;
          img_y  <= img_y + gbrw_pkg::IMG_W'(1);
        end else begin
          cell_y <= cell_y + gbrw_pkg::CELL_W'(1);
        end
      end else begin
        col <= col + gbrw_pkg::CNT_W'(1);
        if (x_wrap) begin
          cell_x <= '0;
          img_x  <= img_x + gbrw_pkg::IMG_W'(1);
        end else begin
          cell_x <= cell_x + gbrw_pkg::CELL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      block_index  <= index_next;
      image_x      <= sat_image(img_x);
      image_y      <= sat_image(img_y);
      last_block   <= at_last;
      span_clipped <= clip;
    end
  end

endmodule

@@ design/grid_block_range_walker.sv @@
// ----------------------------------------------------------------------------
// grid_block_range_walker
// lists the blocks of a uniform 2-D grid that a query rectangle overlaps
// ----------------------------------------------------------------------------
// Each input beat is a rectangle in signed Q16.16; the block answers with one
// output beat per overlapped grid block, rows outer and columns inner, both
// ascending, and marks the final beat with last_block. Per axis the block
// range is floor((coordinate - origin) * inv_block); a closed axis is clamped
// into the grid, a periodic axis wraps the cell and reports the image count.
// An axis covers at most 8 blocks, so a rectangle gives 1 to 64 beats, and
// span_clipped flags every beat of a rectangle that was cut. The front half
// takes one rectangle at a time; its floor divider finds the first cell and
// image count, 4 quotient bits per cycle. The back half issues one beat per
// cycle while out_stall is low. A 2-deep descriptor queue lets the two
// halves overlap. The user must write registers only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module grid_block_range_walker (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration write port
  input  logic                                   cfg_write,
  input  logic [gbrw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gbrw_pkg::CFG_DATA_W-1:0]        cfg_data,
  // rectangle channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [gbrw_pkg::COORD_W-1:0]    rect_xmin,
  input  logic signed [gbrw_pkg::COORD_W-1:0]    rect_xmax,
  input  logic signed [gbrw_pkg::COORD_W-1:0]    rect_ymin,
  input  logic signed [gbrw_pkg::COORD_W-1:0]    rect_ymax,
  // block channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [gbrw_pkg::OUT_W-1:0]             block_index,
  output logic signed [gbrw_pkg::OUT_W-1:0]      image_x,
  output logic signed [gbrw_pkg::OUT_W-1:0]      image_y,
  output logic                                   last_block,
  output logic                                   span_clipped
);

  // configuration registers, as written
  logic signed [gbrw_pkg::COORD_W-1:0] origin_x;
  logic signed [gbrw_pkg::COORD_W-1:0] origin_y;
  logic [gbrw_pkg::COORD_W-1:0]        inv_block_x;
  logic [gbrw_pkg::COORD_W-1:0]        inv_block_y;
  logic [gbrw_pkg::GRID_W-1:0]         blocks_x;
  logic [gbrw_pkg::GRID_W-1:0]         blocks_y;
  logic                                wrap_x;
  logic                                wrap_y;

  gbrw_pkg::cfg_t  cfg;
  gbrw_pkg::desc_t push_desc;
  gbrw_pkg::desc_t pop_desc;
  logic            push, pop, full, empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      inv_block_x <= gbrw_pkg::COORD_W'(65536);
      inv_block_y <= gbrw_pkg::COORD_W'(65536);
      blocks_x    <= gbrw_pkg::GRID_W'(1);
      blocks_y    <= gbrw_pkg::GRID_W'(1);
      wrap_x      <= 1'b0;
      wrap_y      <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        gbrw_pkg::CFG_ORIGIN_X:    origin_x    <= $signed(cfg_data);
        gbrw_pkg::CFG_ORIGIN_Y:    origin_y    <= $signed(cfg_data);
        gbrw_pkg::CFG_INV_BLOCK_X: inv_block_x <= cfg_data;
        gbrw_pkg::CFG_INV_BLOCK_Y: inv_block_y <= cfg_data;
        gbrw_pkg::CFG_BLOCKS_X:    blocks_x    <= cfg_data[gbrw_pkg::GRID_W-1:0];
        gbrw_pkg::CFG_BLOCKS_Y:    blocks_y    <= cfg_data[gbrw_pkg::GRID_W-1:0];
        gbrw_pkg::CFG_WRAP_X:      wrap_x      <= cfg_data[0];
        gbrw_pkg::CFG_WRAP_Y:      wrap_y      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // a block count of zero acts as one, anything past the grid limit as the limit
  always_comb begin
    cfg.origin_x = origin_x;
    cfg.origin_y = origin_y;
    cfg.inv_x    = inv_block_x;
    cfg.inv_y    = inv_block_y;
    cfg.wrap_x   = wrap_x;
    cfg.wrap_y   = wrap_y;
    if (blocks_x == '0) begin
      cfg.n_x = gbrw_pkg::GRID_W'(1);
    end else if (blocks_x > gbrw_pkg::GRID_W'(gbrw_pkg::MAX_GRID)) begin
      cfg.n_x = gbrw_pkg::GRID_W'(gbrw_pkg::MAX_GRID);
    end else begin
      cfg.n_x = blocks_x;
    end
    if (blocks_y == '0) begin
      cfg.n_y = gbrw_pkg::GRID_W'(1);
    end else if (blocks_y > gbrw_pkg::GRID_W'(gbrw_pkg::MAX_GRID)) begin
      cfg.n_y = gbrw_pkg::GRID_W'(gbrw_pkg::MAX_GRID);
    end else begin
      cfg.n_y = blocks_y;
    end
  end

  // front: range per axis and first cell / image count of each
  gbrw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rect_xmin (rect_xmin),
    .rect_xmax (rect_xmax),
    .rect_ymin (rect_ymin),
    .rect_ymax (rect_ymax),
    .push      (push),
    .desc      (push_desc),
    .full      (full)
  );

  // decouples the slow front from the back, which issues one beat per cycle while out_stall is low
  gbrw_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_desc),
    .full  (full),
    .pop   (pop),
    .dout  (pop_desc),
    .empty (empty)
  );

  // back: row by row walk with its own output register
  gbrw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .n_x          (cfg.n_x),
    .n_y          (cfg.n_y),
    .desc         (pop_desc),
    .empty        (empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .block_index  (block_index),
    .image_x      (image_x),
    .image_y      (image_y),
    .last_block   (last_block),
    .span_clipped (span_clipped)
  );

endmodule

@@ design/gbrw_check.sv @@
// ----------------------------------------------------------------------------
// gbrw_check
// port-level checks of the grid block range walker
// ----------------------------------------------------------------------------
module gbrw_check (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [gbrw_pkg::OUT_W-1:0]          block_index,
  input logic signed [gbrw_pkg::OUT_W-1:0]   image_x,
  input logic signed [gbrw_pkg::OUT_W-1:0]   image_y,
  input logic                                last_block,
  input logic                                span_clipped
);

  // reset leaves nothing to deliver and the input open
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("beat pending or input stalled after reset");

  // the front works on one rectangle at a time
  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second rectangle taken while the first is in the front");

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(block_index) && $stable(image_x)
      && $stable(image_y) && $stable(last_block) && $stable(span_clipped))
    else $error("stalled result beat changed");

endmodule

bind grid_block_range_walker gbrw_check u_gbrw_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .block_index  (block_index),
  .image_x      (image_x),
  .image_y      (image_y),
  .last_block   (last_block),
  .span_clipped (span_clipped)
);
